>>> hdl/led_current_frame_packer_defines.svh
// Assertion macros shared by the frame packer modules.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef LED_CURRENT_FRAME_PACKER_DEFINES_SVH
`define LED_CURRENT_FRAME_PACKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LCFP_ASSERT_IMPLY(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lcfp: implication check failed");

// Next-cycle implication, checked outside reset.
`define LCFP_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lcfp: next-cycle check failed");

`endif

>>> hdl/lcfp_pkg.sv
`default_nettype none

package lcfp_pkg;

   // Geometry
   localparam int CHANNELS = 16;
   localparam int CH_W = 4;
   localparam int MAX_DEVICES_DEF = 16;
   localparam int DEVCNT_W = 5;
   localparam int PAD_W = 5;
   localparam int CMP_W = 8;

   // Configuration register indexes
   localparam logic CSR_FULL_SCALE = 1'b0;
   localparam logic CSR_DEVICE_COUNT = 1'b1;

   // Scaling
   localparam int PROD_W = 32;
   localparam int SCALE_SHIFT = 23;
   localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << 22;
   localparam logic [8:0] NINE_BIT_MAX = 9'h1FF;

   // Frame header
   localparam int HDR_BYTES = 4;
   localparam logic [7:0] HDR_BROADCAST = 8'hBF;
   localparam logic [7:0] HDR_LEN = 8'd18;
   localparam logic [7:0] HDR_REG_HI = 8'h00;
   localparam logic [7:0] HDR_REG_LO = 8'h66;

   // Queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   typedef struct packed {
      logic [CH_W-1:0]     ch;
      logic [7:0]          low_byte;
      logic                hdr;
      logic                dump;
      logic [PAD_W-1:0]    pad;
      logic [CHANNELS-1:0] flags;
   } lcfp_entry_type;

   function automatic logic [7:0] bit_rev8(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = b[i];
      end
      return r;
   endfunction

   function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
      logic [7:0] r;
      case (idx)
         2'd0:    r = HDR_BROADCAST;
         2'd1:    r = HDR_LEN;
         2'd2:    r = HDR_REG_HI;
         default: r = HDR_REG_LO;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hdl/lcfp_queue.sv
`default_nettype none

`include "led_current_frame_packer_defines.svh"

module lcfp_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire lcfp_pkg::lcfp_entry_type push_entry,
   input  wire logic                   pop,
   output lcfp_pkg::lcfp_entry_type    pop_entry,
   output logic                        full,
   output logic                        empty
);
   import lcfp_pkg::*;

   lcfp_entry_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign pop_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `LCFP_ASSERT_IMPLY(a_no_push_when_full, push, !full)
   `LCFP_ASSERT_IMPLY(a_count_bounded, 1'b1, count_ff <= QCNT_W'(QUEUE_DEPTH))

endmodule

`default_nettype wire

>>> hdl/lcfp_front.sv
`default_nettype none

module lcfp_front #(
   parameter int MAX_DEVICES = lcfp_pkg::MAX_DEVICES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [15:0]                   req_current_value,
   input  wire logic [15:0]                   full_scale,
   input  wire logic [lcfp_pkg::DEVCNT_W-1:0] device_count,
   output logic                               push,
   output lcfp_pkg::lcfp_entry_type           push_entry,
   input  wire logic                          queue_full
);
   import lcfp_pkg::*;

   localparam int DEV_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

   logic accept;
   logic [CH_W-1:0] chan_ff, chan_in;
   logic [DEV_W-1:0] dev_ff, dev_in;
   logic [CHANNELS-1:0] mask_ff, mask_in;
   logic stage_valid_ff, stage_valid_in;
   logic [PROD_W-1:0] stage_prod_ff, stage_prod_in;
   logic [CH_W-1:0] stage_ch_ff;
   logic stage_hdr_ff, stage_hdr_in;
   logic stage_dump_ff, stage_dump_in;
   logic [PAD_W-1:0] stage_pad_ff, stage_pad_in;

   logic [CMP_W-1:0] devs;
   logic [CMP_W-1:0] dev_next;
   logic last_dev;
   logic [PROD_W:0] rounded;
   logic [9:0] scaled;
   logic [8:0] value9;
   logic [CHANNELS-1:0] mask_base;

   assign req_stall = stage_valid_ff && queue_full;
   assign accept = req_valid && !req_stall;
   assign push = stage_valid_ff && !queue_full;

   // Classify on arrival with the chain length in force now
   always_comb begin
      if (device_count == '0) begin
         devs = CMP_W'(1);
      end else if (CMP_W'(device_count) > CMP_W'(MAX_DEVICES)) begin
         devs = CMP_W'(MAX_DEVICES);
      end else begin
         devs = CMP_W'(device_count);
      end
      dev_next = CMP_W'(dev_ff) + CMP_W'(1);
      last_dev = (dev_next >= devs);

      stage_prod_in = PROD_W'(req_current_value) * PROD_W'(full_scale);
      stage_hdr_in = (chan_ff == '0) && (dev_ff == '0);
      stage_dump_in = (chan_ff == CH_W'(CHANNELS - 1));
      stage_pad_in = (stage_dump_in && last_dev) ? PAD_W'(devs - CMP_W'(1)) : '0;

      chan_in = chan_ff;
      dev_in = dev_ff;
      if (accept) begin
         chan_in = chan_ff + 1'b1;
         if (stage_dump_in) begin
            dev_in = last_dev ? '0 : DEV_W'(dev_next);
         end
      end

      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (push) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   // Round, saturate and fold bit 8 into the flag mask
   always_comb begin
      rounded = {1'b0, stage_prod_ff} + ROUND_HALF;
      scaled = rounded[SCALE_SHIFT+9:SCALE_SHIFT];
      value9 = scaled[9] ? NINE_BIT_MAX : scaled[8:0];
      mask_base = (stage_ch_ff == '0) ? '0 : mask_ff;
      mask_in = mask_base | (CHANNELS'(value9[8]) << stage_ch_ff);

      push_entry.ch = stage_ch_ff;
      push_entry.low_byte = value9[7:0];
      push_entry.hdr = stage_hdr_ff;
      push_entry.dump = stage_dump_ff;
      push_entry.pad = stage_pad_ff;
      push_entry.flags = mask_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= '0;
         dev_ff <= '0;
         mask_ff <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         chan_ff <= chan_in;
         dev_ff <= dev_in;
         stage_valid_ff <= stage_valid_in;
         if (push) begin
            mask_ff <= mask_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_prod_ff <= stage_prod_in;
         stage_ch_ff <= chan_ff;
         stage_hdr_ff <= stage_hdr_in;
         stage_dump_ff <= stage_dump_in;
         stage_pad_ff <= stage_pad_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/lcfp_back.sv
`default_nettype none

`include "led_current_frame_packer_defines.svh"

module lcfp_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    queue_empty,
   input  wire lcfp_pkg::lcfp_entry_type pop_entry,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_run_last
);
   import lcfp_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_HDR  = 3'd1;
   localparam logic [2:0] ST_FLAG = 3'd2;
   localparam logic [2:0] ST_LOW  = 3'd3;
   localparam logic [2:0] ST_PAD  = 3'd4;

   localparam logic [PAD_W-1:0] HDR_LAST = PAD_W'(HDR_BYTES - 1);
   localparam logic [PAD_W-1:0] FLAG_LAST = PAD_W'(1);
   localparam logic [PAD_W-1:0] LOW_LAST = PAD_W'(CHANNELS - 1);

   logic [2:0] state_ff, state_in;
   logic [PAD_W-1:0] cnt_ff, cnt_in;
   logic [CHANNELS-1:0] flags_ff;
   logic [PAD_W-1:0] pad_ff;
   logic [7:0] store_ff [CHANNELS];
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_out_byte_ff, rsp_out_byte_in;
   logic rsp_run_last_ff, rsp_run_last_in;
   logic slot_free;
   logic emit;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = rsp_out_byte_ff;
   assign rsp_run_last = rsp_run_last_ff;

   assign pop = (state_ff == ST_IDLE) && !queue_empty;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign emit = (state_ff != ST_IDLE) && slot_free;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rsp_out_byte_in = 8'h00;
      rsp_run_last_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (pop && pop_entry.hdr) begin
               state_in = ST_HDR;
            end else if (pop && pop_entry.dump) begin
               state_in = ST_FLAG;
            end
         end
         ST_HDR: begin
            rsp_out_byte_in = hdr_byte(cnt_ff[1:0]);
            rsp_run_last_in = (cnt_ff == HDR_LAST);
            if (emit) begin
               cnt_in = (cnt_ff == HDR_LAST) ? '0 : cnt_ff + 1'b1;
               state_in = (cnt_ff == HDR_LAST) ? ST_IDLE : ST_HDR;
            end
         end
         ST_FLAG: begin
            rsp_out_byte_in = (cnt_ff == '0) ? bit_rev8(flags_ff[7:0]) : bit_rev8(flags_ff[15:8]);
            if (emit) begin
               cnt_in = (cnt_ff == FLAG_LAST) ? '0 : cnt_ff + 1'b1;
               state_in = (cnt_ff == FLAG_LAST) ? ST_LOW : ST_FLAG;
            end
         end
         ST_LOW: begin
            rsp_out_byte_in = store_ff[cnt_ff[CH_W-1:0]];
            rsp_run_last_in = (cnt_ff == LOW_LAST) && (pad_ff == '0);
            if (emit) begin
               if (cnt_ff == LOW_LAST) begin
                  cnt_in = '0;
                  state_in = (pad_ff == '0) ? ST_IDLE : ST_PAD;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_PAD: begin
            rsp_run_last_in = (cnt_ff == pad_ff - 1'b1);
            if (emit) begin
               if (cnt_ff == pad_ff - 1'b1) begin
                  cnt_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in = '0;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         store_ff[pop_entry.ch] <= pop_entry.low_byte;
         flags_ff <= pop_entry.flags;
         pad_ff <= pop_entry.pad;
      end
      if (emit) begin
         rsp_out_byte_ff <= rsp_out_byte_in;
         rsp_run_last_ff <= rsp_run_last_in;
      end
   end

   `LCFP_ASSERT_IMPLY(a_pad_nonzero, state_ff == ST_PAD, pad_ff != '0)
   `LCFP_ASSERT_IMPLY(a_hdr_count, state_ff == ST_HDR, cnt_ff <= HDR_LAST)
   `LCFP_ASSERT_NEXT(a_hdr_start, pop && pop_entry.hdr, state_ff == ST_HDR && cnt_ff == '0)

endmodule

`default_nettype wire

>>> hdl/led_current_frame_packer.sv
// LED current frame packer: takes one 16-bit channel current per transfer on the req_ channel,
// in physical channel order, 16 channels per driver device, and returns the bytes of a broadcast
// write frame on the rsp_ channel. Each value is scaled as (value * current_full_scale + 2^22)
// >> 23, clamped at 511. The first channel of a frame yields the header bytes 0xBF, 18, 0x00,
// 0x66; each device's last channel yields two flag bytes (bit 8 of channels 0-7 and 8-15, lowest
// channel in the MSB) and its 16 low bytes; the last device of the chain adds device_count-1 zero
// pad bytes. rsp_run_last marks the final byte caused by one input transfer; channels that cause
// no bytes produce nothing on rsp_. Write the csr_ registers (index 0 gain, index 1 device count,
// 0 treated as 1, values above MAX_DEVICES treated as MAX_DEVICES) only while the block is idle.
// Flow: the front end takes one transfer per cycle while req_stall is low, into a register stage
// (multiply) and a four-entry queue; the back end pops a queued channel only while idle and
// sends all bytes that channel causes before it pops the next, so the back end's byte sequencer
// limits throughput; req_stall rises only when the queue is full.
`default_nettype none

module led_current_frame_packer #(
   parameter int MAX_DEVICES = lcfp_pkg::MAX_DEVICES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_current_value,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_run_last,
   // configuration write port
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_write_data
);
   import lcfp_pkg::*;

   // Configuration registers
   logic [15:0] full_scale_ff, full_scale_in;
   logic [DEVCNT_W-1:0] device_count_ff, device_count_in;

   // Front to queue, queue to back
   logic push;
   lcfp_entry_type push_entry;
   logic queue_full;
   logic pop;
   lcfp_entry_type pop_entry;
   logic queue_empty;

   // Decode the write port; hold both registers otherwise
   always_comb begin
      full_scale_in = full_scale_ff;
      device_count_in = device_count_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FULL_SCALE:   full_scale_in = csr_write_data;
            CSR_DEVICE_COUNT: device_count_in = csr_write_data[DEVCNT_W-1:0];
            default:          full_scale_in = full_scale_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= '0;
         device_count_ff <= DEVCNT_W'(1);
      end else begin
         full_scale_ff <= full_scale_in;
         device_count_ff <= device_count_in;
      end
   end

   // Front end: accept, scale, track channel/device position, build queue entries
   lcfp_front #(
      .MAX_DEVICES(MAX_DEVICES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_current_value(req_current_value),
      .full_scale       (full_scale_ff),
      .device_count     (device_count_ff),
      .push             (push),
      .push_entry       (push_entry),
      .queue_full       (queue_full)
   );

   // Decoupling queue: lets the front keep taking channels while bytes drain
   lcfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .pop_entry (pop_entry),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // Back end: low-byte store and byte sequencer behind an output register
   lcfp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop_entry   (pop_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_run_last(rsp_run_last)
   );

endmodule

`default_nettype wire
